// ----- rtl/lph_pkg.sv -----
// Shared types and constants for the linear probing hash map.
// No dependencies; used by lph_front, lph_back and linear_probe_hash_map.
`default_nettype none
package lph_pkg;
    localparam int SLOTS_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int KEY_W          = 64;
    localparam int LIMIT_W        = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd38;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_SET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_UPDATED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // splitmix64 finaliser constants
    localparam logic [63:0] HASH_ADD = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] HASH_M1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] HASH_M2  = 64'h94D0_49BB_1331_11EB;
endpackage
`default_nettype wire

// ----- rtl/lph_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/lph_front.sv -----
// Front end: accepts requests, hashes the key with a shared 32x32 multiplier,
// and queues the classified request for the back end. Uses lph_pkg.
`default_nettype none
module lph_front #(
    parameter int SLOTS      = lph_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                cmd,
    input  wire logic [63:0]               key,
    input  wire logic [VALUE_BITS-1:0]     new_value,
    output logic                           q_valid,
    input  wire logic                      q_pop,
    output lph_pkg::cmd_t                  q_cmd,
    output logic [63:0]                    q_key,
    output logic [VALUE_BITS-1:0]          q_value,
    output logic [$clog2(SLOTS)-1:0]       q_home
);
    localparam int H = $clog2(SLOTS);

    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_MIX  = 7'b0000010,
        F_M0   = 7'b0000100,
        F_M1   = 7'b0001000,
        F_M2   = 7'b0010000,
        F_M3   = 7'b0100000,
        F_PUSH = 7'b1000000
    } fstate_t;

    fstate_t                 state_reg;
    lph_pkg::cmd_t           cmd_reg;
    logic [63:0]             key_reg;
    logic [VALUE_BITS-1:0]   val_reg;
    logic [63:0]             a_reg;
    logic [63:0]             m_reg;
    logic [63:0]             acc_reg;
    logic [63:0]             prod_reg;
    logic                    pass_reg;
    logic [H-1:0]            home_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mix0;
    logic [63:0] prod_sum;

    // two-entry queue
    lph_pkg::cmd_t         qc_reg [2];
    logic [63:0]           qk_reg [2];
    logic [VALUE_BITS-1:0] qv_reg [2];
    logic [H-1:0]          qh_reg [2];
    logic                  wp_reg;
    logic                  rp_reg;
    logic [1:0]            qn_reg;
    logic                  push;
    logic                  pop;

    assign in_stall = (state_reg != F_IDLE);
    assign push     = (state_reg == F_PUSH) && (qn_reg != 2'd2);
    assign pop      = q_pop && (qn_reg != 2'd0);
    assign q_valid  = (qn_reg != 2'd0);
    assign q_cmd    = qc_reg[rp_reg];
    assign q_key    = qk_reg[rp_reg];
    assign q_value  = qv_reg[rp_reg];
    assign q_home   = qh_reg[rp_reg];

    always_comb
    begin
        mix0 = key_reg + lph_pkg::HASH_ADD;
        mix0 = mix0 ^ (mix0 >> 30);
        mul_a = a_reg[31:0];
        mul_b = m_reg[31:0];
        if (state_reg == F_M1)
        begin
            mul_b = m_reg[63:32];
        end
        else if (state_reg == F_M2)
        begin
            mul_a = a_reg[63:32];
        end
        prod_sum = acc_reg + {prod_reg[31:0], 32'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            qn_reg    <= 2'd0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= (lph_pkg::cmd_t'(cmd) == lph_pkg::CMD_CLEAR) ?
                                     F_PUSH : F_MIX;
                    end
                end
                F_MIX:  state_reg <= F_M0;
                F_M0:   state_reg <= F_M1;
                F_M1:   state_reg <= F_M2;
                F_M2:   state_reg <= F_M3;
                F_M3:   state_reg <= pass_reg ? F_PUSH : F_M0;
                F_PUSH:
                begin
                    if (push)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            qn_reg <= qn_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            cmd_reg <= lph_pkg::cmd_t'(cmd);
            key_reg <= key;
            val_reg <= new_value;
        end
        if (state_reg == F_MIX)
        begin
            a_reg    <= mix0;
            m_reg    <= lph_pkg::HASH_M1;
            pass_reg <= 1'b0;
        end
        prod_reg <= mul_a * mul_b;
        if (state_reg == F_M1)
        begin
            acc_reg <= prod_reg;
        end
        if (state_reg == F_M2)
        begin
            acc_reg <= prod_sum;
        end
        if (state_reg == F_M3)
        begin
            if (!pass_reg)
            begin
                a_reg    <= prod_sum ^ (prod_sum >> 27);
                m_reg    <= lph_pkg::HASH_M2;
                pass_reg <= 1'b1;
            end
            else
            begin
                home_reg <= prod_sum[H-1:0] ^ prod_sum[31 +: H];
            end
        end
        if (push)
        begin
            qc_reg[wp_reg] <= cmd_reg;
            qk_reg[wp_reg] <= key_reg;
            qv_reg[wp_reg] <= val_reg;
            qh_reg[wp_reg] <= home_reg;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/lph_back.sv -----
// Back end: probes the slot store, carries out lookup, set, remove (with
// backward-shift deletion) and clear, and holds the result. Uses lph_pkg, lph_ram.
`default_nettype none
module lph_back #(
    parameter int SLOTS      = lph_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [lph_pkg::LIMIT_W-1:0]   load_limit,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  wire lph_pkg::cmd_t                 q_cmd,
    input  wire logic [63:0]                   q_key,
    input  wire logic [VALUE_BITS-1:0]         q_value,
    input  wire logic [$clog2(SLOTS)-1:0]      q_home,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic [VALUE_BITS-1:0]              value_out,
    output logic [$clog2(SLOTS+1)-1:0]         entry_count
);
    localparam int H  = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS+1);
    localparam int EW = 64 + VALUE_BITS + H;
    localparam logic [H-1:0] LAST = H'(SLOTS - 1);

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_RD    = 6'b000010,
        B_CMP   = 6'b000100,
        B_DSTEP = 6'b001000,
        B_DCMP  = 6'b010000,
        B_DONE  = 6'b100000
    } bstate_t;

    bstate_t               state_reg;
    lph_pkg::cmd_t         cmd_reg;
    logic [63:0]           key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [H-1:0]          idx_reg;
    logic [H-1:0]          n_reg;
    logic [H-1:0]          hole_reg;
    logic [SLOTS-1:0]      used_reg;
    logic [CW-1:0]         count_reg;
    logic [2:0]            res_st_reg;
    logic [VALUE_BITS-1:0] res_val_reg;
    logic                  out_valid_reg;
    logic [2:0]            out_st_reg;
    logic [VALUE_BITS-1:0] out_val_reg;
    logic [CW-1:0]         out_cnt_reg;

    logic                  wr_en;
    logic [H-1:0]          wr_addr;
    logic [EW-1:0]         wr_data;
    logic                  rd_en;
    logic [H-1:0]          rd_addr;
    logic [EW-1:0]         rd_data;
    logic [63:0]           rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [H-1:0]          rd_home;
    logic [H-1:0]          jn;
    logic                  room;
    logic                  hit;

    assign rd_key  = rd_data[EW-1 -: 64];
    assign rd_val  = rd_data[H +: VALUE_BITS];
    assign rd_home = rd_data[H-1:0];
    assign jn      = idx_reg + 1'b1;
    assign hit     = used_reg[idx_reg] && (rd_key == key_reg);
    assign room    = ({{(32-CW){1'b0}}, count_reg} <
                      {{(32-lph_pkg::LIMIT_W){1'b0}}, load_limit});
    assign q_pop   = (state_reg == B_IDLE) && q_valid;

    assign out_valid   = out_valid_reg;
    assign status      = out_st_reg;
    assign value_out   = out_val_reg;
    assign entry_count = out_cnt_reg;

    lph_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = {key_reg, val_reg, q_home};
        if (state_reg == B_RD)
        begin
            rd_en = 1'b1;
        end
        else if (state_reg == B_DSTEP)
        begin
            rd_en   = 1'b1;
            rd_addr = jn;
        end
        else if (state_reg == B_CMP)
        begin
            if (!used_reg[idx_reg])
            begin
                wr_en   = (cmd_reg == lph_pkg::CMD_SET) && room;
                wr_data = {key_reg, val_reg, hole_reg};
            end
            else if (hit)
            begin
                wr_en   = (cmd_reg == lph_pkg::CMD_SET);
                wr_data = {key_reg, val_reg, rd_home};
            end
        end
        else if (state_reg == B_DCMP)
        begin
            // move the entry back if the hole lies within its probe run
            wr_en   = ((idx_reg - rd_home) >= (idx_reg - hole_reg));
            wr_addr = hole_reg;
            wr_data = rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            used_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == B_DONE && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_cmd == lph_pkg::CMD_CLEAR)
                        begin
                            used_reg  <= '0;
                            count_reg <= '0;
                            state_reg <= B_DONE;
                        end
                        else
                        begin
                            state_reg <= B_RD;
                        end
                    end
                end
                B_RD: state_reg <= B_CMP;
                B_CMP:
                begin
                    if (!used_reg[idx_reg])
                    begin
                        if (cmd_reg == lph_pkg::CMD_SET && room)
                        begin
                            used_reg[idx_reg] <= 1'b1;
                            count_reg         <= count_reg + 1'b1;
                        end
                        state_reg <= B_DONE;
                    end
                    else if (hit)
                    begin
                        if (cmd_reg == lph_pkg::CMD_REMOVE)
                        begin
                            if (count_reg != '0)
                            begin
                                count_reg <= count_reg - 1'b1;
                            end
                            state_reg <= B_DSTEP;
                        end
                        else
                        begin
                            state_reg <= B_DONE;
                        end
                    end
                    else if (n_reg == LAST)
                    begin
                        state_reg <= B_DONE;
                    end
                    else
                    begin
                        state_reg <= B_RD;
                    end
                end
                B_DSTEP:
                begin
                    if (n_reg == LAST || !used_reg[jn])
                    begin
                        used_reg[hole_reg] <= 1'b0;
                        state_reg          <= B_DONE;
                    end
                    else
                    begin
                        state_reg <= B_DCMP;
                    end
                end
                B_DCMP: state_reg <= B_DSTEP;
                B_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                cmd_reg     <= q_cmd;
                key_reg     <= q_key;
                val_reg     <= q_value;
                hole_reg    <= q_home;
                idx_reg     <= q_home;
                n_reg       <= '0;
                res_st_reg  <= lph_pkg::ST_DONE;
                res_val_reg <= '0;
            end
            B_CMP:
            begin
                if (!used_reg[idx_reg])
                begin
                    if (cmd_reg == lph_pkg::CMD_SET)
                    begin
                        res_st_reg <= room ? lph_pkg::ST_INSERTED : lph_pkg::ST_FULL;
                    end
                    else
                    begin
                        res_st_reg <= lph_pkg::ST_NOT_FOUND;
                    end
                end
                else if (hit)
                begin
                    res_val_reg <= rd_val;
                    res_st_reg  <= (cmd_reg == lph_pkg::CMD_SET) ?
                                   lph_pkg::ST_UPDATED : lph_pkg::ST_DONE;
                    hole_reg    <= idx_reg;
                    n_reg       <= '0;
                end
                else if (n_reg == LAST)
                begin
                    res_st_reg <= (cmd_reg == lph_pkg::CMD_SET) ?
                                  lph_pkg::ST_FULL : lph_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    idx_reg <= jn;
                    n_reg   <= n_reg + 1'b1;
                end
            end
            B_DSTEP:
            begin
                idx_reg <= jn;
                n_reg   <= n_reg + 1'b1;
            end
            B_DCMP:
            begin
                if (wr_en)
                begin
                    hole_reg <= idx_reg;
                end
            end
            B_DONE:
            begin
                // load only when the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_st_reg  <= res_st_reg;
                    out_val_reg <= res_val_reg;
                    out_cnt_reg <= count_reg;
                end
            end
            default:
            begin
                n_reg <= n_reg;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/linear_probe_hash_map.sv -----
// Linear probing hash map, 64-bit keys, VALUE_BITS-bit values, SLOTS slots.
// Request channel (in_valid/in_stall): cmd, key, new_value; an item is taken
// when in_valid is high and in_stall low. Result channel (out_valid/out_stall):
// status, value_out, entry_count, one result per request, in request order.
// Config channel (cfg_valid/cfg_ready): writes load_limit; ready is always high.
// The front end hashes the key (splitmix64 finaliser) on one shared 32x32
// multiplier (F_MIX, F_M0 to F_M3 twice, F_PUSH); a clear goes to F_PUSH
// directly; in_stall is high whenever the front end is not in F_IDLE. A
// two-entry queue feeds the back end, which probes the slot RAM one slot at a
// time (B_RD, B_CMP); a remove scans on via B_DSTEP, B_DCMP to shift back.
// Sustained rate is set by the hash sequencer, or by long probe chains.
// Reset clears all used bits and the entry count at once, sets load_limit to 38.
// A stalled result is held in the output register; the back end waits, the
// queue fills, and the front end then waits in F_PUSH with in_stall high.
// Depends on lph_pkg, lph_front, lph_back, lph_ram.
`default_nettype none
module linear_probe_hash_map #(
    parameter int SLOTS      = lph_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    cmd,
    input  wire logic [63:0]                   key,
    input  wire logic [VALUE_BITS-1:0]         new_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic [VALUE_BITS-1:0]              value_out,
    output logic [$clog2(SLOTS+1)-1:0]         entry_count,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lph_pkg::LIMIT_W-1:0]   cfg_data
);
    localparam int H = $clog2(SLOTS);

    logic [lph_pkg::LIMIT_W-1:0] limit_reg;
    logic                        q_valid;
    logic                        q_pop;
    lph_pkg::cmd_t               q_cmd;
    logic [63:0]                 q_key;
    logic [VALUE_BITS-1:0]       q_value;
    logic [H-1:0]                q_home;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= lph_pkg::LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    lph_front #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key       (key),
        .new_value (new_value),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .q_key     (q_key),
        .q_value   (q_value),
        .q_home    (q_home)
    );

    lph_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_limit  (limit_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_cmd       (q_cmd),
        .q_key       (q_key),
        .q_value     (q_value),
        .q_home      (q_home),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({{(32-$clog2(SLOTS+1)){1'b0}}, entry_count} <= SLOTS))
        else $error("entry count beyond table size");
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == lph_pkg::ST_INSERTED |-> entry_count != '0)
        else $error("insert reported with empty table");
    a_unused_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == lph_pkg::ST_INSERTED || status == lph_pkg::ST_NOT_FOUND
                      || status == lph_pkg::ST_FULL) |-> value_out == '0)
        else $error("value_out not zero where unused");
`endif
endmodule
`default_nettype wire
